[sv/ilist_pkg.sv]
// Shared types and constants for the indexed list block.
`timescale 1ns / 1ps
package ilist_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned POS_W   = 13;

  typedef enum logic [FUNC_W-1:0] {
    FN_READ     = 3'd0,
    FN_INS_HEAD = 3'd1,
    FN_INS_TAIL = 3'd2,
    FN_INS_IDX  = 3'd3,
    FN_DEL_IDX  = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

[sv/ilist_cell.sv]
// One list entry: holds, loads the new value, or shifts from a neighbor.
`timescale 1ns / 1ps
module ilist_cell
  import ilist_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] prev_i,
  input  logic [DATA_W-1:0] next_i,
  output logic [DATA_W-1:0] data_o,
  output logic [DATA_W-1:0] rd_o
);

  localparam logic [POS_W-1:0] MyPos = POS_W'(IDX);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INS: begin
        if (MyPos == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end else if (MyPos > ctrl_i.pos) begin
          data_d = prev_i;
        end
      end
      CELL_DEL: begin
        if (MyPos >= ctrl_i.pos) begin
          data_d = next_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (MyPos == ctrl_i.pos) ? data_q : '0;

endmodule

[sv/indexed_list_insert_delete.sv]
// Top level of the indexed list: request decode, count, cell row and result register.
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// one entry per cell. A new request can be taken every cycle while in_stall_o
// is low; every cell shifts at once on an insert or a delete, so the shift
// length does not affect timing. The result appears in the output register in
// the cycle after the request is accepted and is held while out_stall_i is
// high; in_stall_o rises only while that register holds a result that is
// being stalled. Entries are not cleared at reset.
`timescale 1ns / 1ps
module indexed_list_insert_delete
  import ilist_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic [INDEX_W-1:0]       index_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [LEN_W-1:0]         length_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  logic              in_acc;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     count_d;
  logic              out_valid_q;
  logic [DATA_W-1:0] read_value_q;
  logic [DATA_W-1:0] read_value_d;
  status_e           status_q;
  status_e           status_d;
  logic [LEN_W-1:0]  length_q;
  cell_ctrl_t        ctrl;
  logic [POS_W-1:0]  idx_w;
  logic [POS_W-1:0]  cnt_w;
  logic              full;
  logic [DATA_W-1:0] rd_or;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign idx_w      = POS_W'(index_i);
  assign cnt_w      = POS_W'(count_q);
  assign full       = (count_q == CapCount);

  always_comb begin
    rd_or = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    ctrl.op      = CELL_HOLD;
    ctrl.pos     = idx_w;
    ctrl.value   = value_i;
    count_d      = count_q;
    status_d     = ST_RANGE;
    read_value_d = '0;
    case (func_e'(func_i))
      FN_READ: begin
        if (idx_w < cnt_w) begin
          status_d     = ST_DONE;
          read_value_d = rd_or;
        end else begin
          read_value_d = '1;
        end
      end
      FN_INS_HEAD, FN_INS_TAIL: begin
        ctrl.pos = (func_e'(func_i) == FN_INS_HEAD) ? '0 : cnt_w;
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_DONE;
          ctrl.op  = CELL_INS;
          count_d  = count_q + CW'(1);
        end
      end
      FN_INS_IDX: begin
        if (idx_w > cnt_w) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_DONE;
          ctrl.op  = CELL_INS;
          count_d  = count_q + CW'(1);
        end
      end
      FN_DEL_IDX: begin
        if (idx_w < cnt_w) begin
          status_d = ST_DONE;
          ctrl.op  = CELL_DEL;
          count_d  = count_q - CW'(1);
        end
      end
      default: status_d = ST_RANGE;
    endcase
    if (!in_acc) begin
      ctrl.op = CELL_HOLD;
      count_d = count_q;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] prev;
    logic [DATA_W-1:0] next;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid
      assign prev = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next = '0;
    end else begin : g_inner
      assign next = cell_data[g+1];
    end
    ilist_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .ctrl_i(ctrl),
      .prev_i(prev),
      .next_i(next),
      .data_o(cell_data[g]),
      .rd_o  (cell_rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      read_value_q <= read_value_d;
      status_q     <= status_d;
      length_q     <= LEN_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign length_o     = length_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCount)
    else $error("count exceeds capacity");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(count_q))
    else $error("count changed without an accepted item");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted item produced no result");

  a_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_FULL |-> length_q == LEN_W'(CAPACITY))
    else $error("full status with list not full");

endmodule
